// File: hw/rtl/json_string_unescape_unit_assert.svh
// assertion macros shared by the json string unescape rtl
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define JSU_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`define JSU_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JSU_ASSERT_NEVER(lbl, cond)
`define JSU_ASSERT_IMPLY(lbl, ante, cons)
`define JSU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/jsu_pkg.sv
// shared types, codes and helper functions of the json string unescaper
package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd2;
    localparam logic [2:0] ERR_SHORT_UNI  = 3'd3;
    localparam logic [2:0] ERR_UNTERM     = 3'd4;
    localparam logic [2:0] ERR_EMPTY      = 3'd5;

    // utf-8 lead and continuation marks
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // work handed from front to back
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_DONE,
        OP_ERR,
        OP_UCP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] data;
        logic [2:0]  err;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } esc_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h37);
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    // single-byte escape letters; the unicode escape is handled apart
    function automatic esc_t escape_decode(input logic [7:0] c);
        esc_t r;
        r.valid = 1'b1;
        case (c)
            8'h22:   r.value = 8'h22;
            8'h5C:   r.value = 8'h5C;
            8'h2F:   r.value = 8'h2F;
            8'h6E:   r.value = 8'h0A;
            8'h72:   r.value = 8'h0D;
            8'h74:   r.value = 8'h09;
            8'h62:   r.value = 8'h08;
            8'h66:   r.value = 8'h0C;
            default:
            begin
                r.valid = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/json_string_unescape_unit.sv
// json string unescaper: a parsing front end, a command queue and a result back end
// path: command queue, current-command register, then the output register
// throughput: one input beat per cycle while the queue has room; a unicode escape expands to
// up to three result beats, drained one per cycle while popped; the queue absorbs the burst
// reset: asynchronous, active low; clears parser state, queue pointers and output valid
module json_string_unescape_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input side, queue-like
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       input_ended,
    // result side, queue-like
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [1:0] result_kind,
    output logic [2:0] error_code,
    output logic       last
);

    // an input beat is taken whenever the command queue has room;
    // the front end never stalls on its own, so full is the queue's full
    logic in_accept;
    logic cmd_valid;
    cmd_t cmd;
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    cmd_t q_data;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    // front: tracks idle / string / escape / hex mode and issues one command
    // per beat that produces results (blanks, quote openings and partial
    // escapes issue nothing)
    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_accept),
        .in_byte     (in_byte),
        .input_ended (input_ended),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    // decoupling queue, lets the front keep going while the back emits
    // multi-byte utf-8 sequences or the result side stalls
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // back: one result beat per cycle into the output register while it is free or popped,
    // with the last flag set on the final beat of each command
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .error_code  (error_code),
        .last        (last)
    );

endmodule

// File: hw/rtl/jsu_front.sv
// front end: parses the input stream and issues decode commands
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       input_ended,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STR,
        ST_ESC,
        ST_HEX
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  seen_reg, seen_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] cp_shift;
    hex_t        hx;
    esc_t        es;

    assign hx       = hex_decode(in_byte);
    assign es       = escape_decode(in_byte);
    assign cp_shift = {cp_reg[11:0], hx.value};

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        cp_next    = cp_reg;
        cmd_valid  = 1'b0;
        cmd.op     = OP_BYTE;
        cmd.data   = {8'h00, in_byte};
        cmd.err    = ERR_NO_QUOTE;
        case (state_reg)
            ST_IDLE:
            begin
                if (input_ended) begin
                    cmd_valid = 1'b1;
                    cmd.op    = OP_ERR;
                    cmd.err   = ERR_EMPTY;
                end else if (in_byte inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
                    state_next = ST_IDLE;
                end else if (in_byte == 8'h22) begin
                    state_next = ST_STR;
                end else begin
                    cmd_valid = 1'b1;
                    cmd.op    = OP_ERR;
                    cmd.err   = ERR_NO_QUOTE;
                end
            end
            ST_STR:
            begin
                cmd_valid = 1'b1;
                if (input_ended) begin
                    cmd.op     = OP_ERR;
                    cmd.err    = ERR_UNTERM;
                    state_next = ST_IDLE;
                end else if (in_byte == 8'h22) begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end else if (in_byte == 8'h5C) begin
                    cmd_valid  = 1'b0;
                    state_next = ST_ESC;
                end
            end
            ST_ESC:
            begin
                cmd_valid = 1'b1;
                if (input_ended) begin
                    cmd.op     = OP_ERR;
                    cmd.err    = ERR_BAD_ESCAPE;
                    state_next = ST_IDLE;
                end else if (in_byte == 8'h75) begin
                    cmd_valid  = 1'b0;
                    seen_next  = 2'd0;
                    cp_next    = 16'h0000;
                    state_next = ST_HEX;
                end else if (es.valid) begin
                    cmd.data   = {8'h00, es.value};
                    state_next = ST_STR;
                end else begin
                    cmd.op     = OP_ERR;
                    cmd.err    = ERR_BAD_ESCAPE;
                    state_next = ST_IDLE;
                end
            end
            ST_HEX:
            begin
                if (input_ended || !hx.valid) begin
                    cmd_valid  = 1'b1;
                    cmd.op     = OP_ERR;
                    cmd.err    = input_ended ? ERR_SHORT_UNI : ERR_BAD_HEX;
                    seen_next  = 2'd0;
                    cp_next    = 16'h0000;
                    state_next = ST_IDLE;
                end else if (seen_reg == 2'd3) begin
                    cmd_valid  = 1'b1;
                    cmd.op     = OP_UCP;
                    cmd.data   = cp_shift;
                    seen_next  = 2'd0;
                    cp_next    = 16'h0000;
                    state_next = ST_STR;
                end else begin
                    cp_next   = cp_shift;
                    seen_next = seen_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (!in_valid) begin
            cmd_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            seen_reg  <= 2'd0;
            cp_reg    <= 16'h0000;
        end else if (in_valid) begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            cp_reg    <= cp_next;
        end
    end

endmodule

// File: hw/rtl/jsu_queue.sv
// small command queue between front and back
`include "json_string_unescape_unit_assert.svh"
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `JSU_ASSERT_NEVER(a_count_bound, count_reg > CW'(DEPTH))
    `JSU_ASSERT_NEVER(a_push_when_full, push && full)
    `JSU_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1))

endmodule

// File: hw/rtl/jsu_back.sv
// back end: expands commands into result beats and holds the output register
`include "json_string_unescape_unit_assert.svh"
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  cmd_t       q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic [1:0] result_kind,
    output logic [2:0] error_code,
    output logic       last
);

    cmd_t        cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  step_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  code_reg;
    logic        last_reg;

    logic [15:0] cp;
    logic [1:0]  nbytes;
    logic        step_final;
    logic        advance;
    logic [7:0]  byte_next;
    logic [1:0]  kind_next;
    logic [2:0]  code_next;

    assign cp = cur_reg.data;

    always_comb
    begin
        if (cp[15:11] != '0) begin
            nbytes = 2'd3;
        end else if (cp[10:7] != '0) begin
            nbytes = 2'd2;
        end else begin
            nbytes = 2'd1;
        end
    end

    assign step_final = (cur_reg.op != OP_UCP) || (step_reg == nbytes - 2'd1);
    assign advance    = cur_valid_reg && (!out_valid_reg || pop);
    assign q_pop      = q_not_empty && (!cur_valid_reg || (advance && step_final));

    always_comb
    begin
        byte_next = 8'h00;
        kind_next = KIND_DATA;
        code_next = 3'd0;
        case (cur_reg.op)
            OP_BYTE:
            begin
                byte_next = cp[7:0];
            end
            OP_DONE:
            begin
                kind_next = KIND_DONE;
            end
            OP_ERR:
            begin
                kind_next = KIND_ERR;
                code_next = cur_reg.err;
            end
            OP_UCP:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        if (nbytes == 2'd1) begin
                            byte_next = cp[7:0];
                        end else if (nbytes == 2'd2) begin
                            byte_next = UTF8_LEAD2 | {3'b000, cp[10:6]};
                        end else begin
                            byte_next = UTF8_LEAD3 | {4'h0, cp[15:12]};
                        end
                    end
                    2'd1:
                    begin
                        if (nbytes == 2'd2) begin
                            byte_next = UTF8_CONT | {2'b00, cp[5:0]};
                        end else begin
                            byte_next = UTF8_CONT | {2'b00, cp[11:6]};
                        end
                    end
                    default:
                    begin
                        byte_next = UTF8_CONT | {2'b00, cp[5:0]};
                    end
                endcase
            end
            default:
            begin
                byte_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (step_final) begin
                    cur_valid_reg <= 1'b0;
                    step_reg      <= 2'd0;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end else if (pop && out_valid_reg) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (advance) begin
            byte_reg <= byte_next;
            kind_reg <= kind_next;
            code_reg <= code_next;
            last_reg <= step_final;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = byte_reg;
    assign result_kind = kind_reg;
    assign error_code  = code_reg;
    assign last        = last_reg;

    `JSU_ASSERT_NEVER(a_step_bound, step_reg == 2'd3)
    `JSU_ASSERT_IMPLY(a_step_only_ucp, cur_valid_reg && step_reg != 2'd0, cur_reg.op == OP_UCP)
    `JSU_ASSERT_IMPLY(a_end_beat_last, out_valid_reg && kind_reg != KIND_DATA, last_reg)

endmodule
